// ===== hw/rtl/btpc_pkg.sv =====
// Package for the barometric temperature and pressure compensation block.
// Holds shared types, register codes and arithmetic helper functions.
// No dependencies.
package btpc_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);
    localparam int DIV_W   = 64;

    typedef enum logic [1:0] {
        REG_TEMP       = 2'd0,
        REG_PRESS_A    = 2'd1,
        REG_PRESS_B    = 2'd2,
        REG_PRESS_NINE = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coef;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] d;
        logic        [19:0] adc_p;
    } t_fentry;

    typedef struct packed {
        logic [23:0] temp;
        logic [31:0] fine;
        logic        zero;
    } t_side;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvd;
    } t_dstep;

    function automatic logic signed [16:0] f_s17(input logic [15:0] v);
        return $signed({v[15], v});
    endfunction

    // Low partial product: unsigned low word of a times signed b, sign-extended.
    function automatic logic [63:0] f_pp_lo(input logic [63:0] a, input logic signed [16:0] b);
        logic signed [49:0] t;
        t = $signed({1'b0, a[31:0]}) * b;
        return {{14{t[49]}}, t};
    endfunction

    // High partial product: only its low word survives the 64-bit wrap.
    function automatic logic [31:0] f_pp_hi(input logic [63:0] a, input logic signed [16:0] b);
        logic signed [48:0] t;
        t = $signed(a[63:32]) * b;
        return t[31:0];
    endfunction

    function automatic logic [63:0] f_pp_sum(input logic [63:0] lo, input logic [31:0] hi);
        return lo + {hi, 32'b0};
    endfunction

    // One restoring division step producing one quotient bit.
    function automatic t_dstep f_div_step(input logic [DIV_W-1:0] rem,
                                          input logic [DIV_W-1:0] dvd,
                                          input logic [DIV_W-1:0] mb);
        logic [DIV_W+1:0] diff;
        t_dstep           r;
        diff = {1'b0, rem, dvd[DIV_W-1]} - {2'b0, mb};
        if (diff[DIV_W+1]) begin
            r.rem = {rem[DIV_W-2:0], dvd[DIV_W-1]};
        end else begin
            r.rem = diff[DIV_W-1:0];
        end
        r.dvd = {dvd[DIV_W-2:0], ~diff[DIV_W+1]};
        return r;
    endfunction

endpackage

// ===== hw/rtl/btpc_front.sv =====
// Front end: takes a raw reading pair and forms the first temperature terms.
// Depends on btpc_pkg.
module btpc_front import btpc_pkg::*; (
    input  logic        i_in_valid,
    input  logic        i_q_stall,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    input  logic [15:0] i_t1,
    output logic        o_push,
    output t_fentry     o_entry
);

    assign o_push = i_in_valid && !i_q_stall;

    always_comb begin
        o_entry.a     = $signed({15'b0, i_raw_temperature[19:3]})
                      - $signed({15'b0, i_t1, 1'b0});
        o_entry.d     = $signed({16'b0, i_raw_temperature[19:4]})
                      - $signed({16'b0, i_t1});
        o_entry.adc_p = i_raw_pressure;
    end

endmodule

// ===== hw/rtl/btpc_fifo.sv =====
// Short queue between the front end and the compensation pipeline.
// Depends on btpc_pkg.
module btpc_fifo import btpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_fentry i_data,
    input  logic    i_pop,
    output logic    o_stall,
    output logic    o_empty,
    output t_fentry o_data
);

    t_fentry             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]     r_wp;
    logic [Q_AW-1:0]     r_rp;
    logic [Q_CW-1:0]     r_cnt;

    assign o_stall = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CW'(Q_DEPTH)) else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_cnt == '0)) else $error("pop from empty queue");
    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not rise on push");
    a_cnt_dn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("queue count did not fall on pop");

endmodule

// ===== hw/rtl/btpc_div.sv =====
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Depends on btpc_pkg.
module btpc_div import btpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    input  t_side            i_side,
    output logic             o_vld,
    output logic [DIV_W-1:0] o_quo,
    output t_side            o_side
);

    logic [DIV_W-1:0] r_rem  [DIV_W+1];
    logic [DIV_W-1:0] r_dvd  [DIV_W+1];
    logic [DIV_W-1:0] r_mb   [DIV_W+1];
    logic             r_neg  [DIV_W+1];
    t_side            r_side [DIV_W+1];
    logic [DIV_W:0]   r_vld;
    logic [DIV_W-1:0] r_quo;
    t_side            r_qside;
    logic             r_qvld;
    t_dstep           c_step [DIV_W];

    always_comb begin
        for (int k = 0; k < DIV_W; k++) begin
            c_step[k] = f_div_step(r_rem[k], r_dvd[k], r_mb[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_qvld <= 1'b0;
        end else if (i_adv) begin
            r_vld  <= {r_vld[DIV_W-1:0], i_vld};
            r_qvld <= r_vld[DIV_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0]  <= '0;
            r_dvd[0]  <= i_num[DIV_W-1] ? (~i_num + 1'b1) : i_num;
            r_mb[0]   <= i_den[DIV_W-1] ? (~i_den + 1'b1) : i_den;
            r_neg[0]  <= i_num[DIV_W-1] ^ i_den[DIV_W-1];
            r_side[0] <= i_side;
            for (int k = 0; k < DIV_W; k++) begin
                r_rem[k+1]  <= c_step[k].rem;
                r_dvd[k+1]  <= c_step[k].dvd;
                r_mb[k+1]   <= r_mb[k];
                r_neg[k+1]  <= r_neg[k];
                r_side[k+1] <= r_side[k];
            end
            r_quo   <= r_neg[DIV_W] ? (~r_dvd[DIV_W] + 1'b1) : r_dvd[DIV_W];
            r_qside <= r_side[DIV_W];
        end
    end

    assign o_vld  = r_qvld;
    assign o_quo  = r_quo;
    assign o_side = r_qside;

endmodule

// ===== hw/rtl/btpc_back.sv =====
// Back end: temperature and pressure compensation pipeline with output register.
// Depends on btpc_pkg and btpc_div.
module btpc_back import btpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_coef       i_coef,
    input  logic        i_q_empty,
    input  t_fentry     i_q_data,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [23:0] o_temperature_centi,
    output logic [23:0] o_pressure_pa,
    output logic [31:0] o_fine_temperature
);

    logic        adv;
    logic [8:1]  r_vld;
    logic [3:1]  r_pv;
    logic        r_out_vld;

    logic signed [31:0] r1_xt, r1_dd;
    logic        [19:0] r1_adcp, r2_adcp, r3_adcp, r4_adcp, r5_adcp;
    logic signed [31:0] r2_fine;
    logic        [31:0] r3_fine, r4_fine, r5_fine, r6_fine, r7_fine, r8_fine;
    logic        [23:0] r3_temp, r4_temp, r5_temp, r6_temp, r7_temp, r8_temp;
    logic        [63:0] r3_xx, r3_xp5, r3_xp2;
    logic        [63:0] r4_l6, r4_l3, r4_xp5, r4_xp2;
    logic        [31:0] r4_h6, r4_h3;
    logic        [63:0] r5_y, r5_xv;
    logic        [63:0] r6_l1, r6_num0;
    logic        [31:0] r6_h1;
    logic        [63:0] r7_den, r7_l;
    logic        [31:0] r7_h;
    logic        [63:0] r8_num, r8_den;

    logic signed [31:0] c1_xt, c1_dd, c2_yy, c2_fine, c3_t32;
    logic signed [32:0] c3_x;
    logic signed [65:0] c3_xx;
    logic signed [49:0] c3_xp5, c3_xp2;
    logic signed [63:0] c5_xxp3, c7_den;
    logic        [20:0] c6_pn;

    logic               dv_vld;
    logic        [63:0] dv_quo;
    t_side              dv_side, s8_side;

    logic signed [63:0] cp_s, cp_p8, cp_x9, cp_sum, cp_pr;
    logic        [63:0] r_p1_ll, r_p1_l8, r_p1_q, r_p2_ss, r_p2_q, r_p2_yv;
    logic        [31:0] r_p1_hl, r_p1_h8;
    logic        [63:0] r_p3_l9, r_p3_q, r_p3_yv;
    logic        [31:0] r_p3_h9;
    t_side              r_p1_side, r_p2_side, r_p3_side;
    logic        [23:0] r_out_temp, r_out_pres;
    logic        [31:0] r_out_fine;

    assign adv     = !r_out_vld || !i_out_stall;
    assign o_q_pop = adv && !i_q_empty;

    always_comb begin
        c1_xt   = $signed(i_q_data.a) * $signed(i_coef.t2);
        c1_dd   = $signed(i_q_data.d) * $signed(i_q_data.d);
        c2_yy   = r1_dd * $signed(i_coef.t3);
        c2_fine = r1_xt + (c2_yy >>> 14);
        c3_t32  = ((r2_fine <<< 2) + r2_fine + 32'sd128) >>> 8;
        c3_x    = $signed({r2_fine[31], r2_fine}) - 33'sd128000;
        c3_xx   = c3_x * c3_x;
        c3_xp5  = c3_x * f_s17(i_coef.p5);
        c3_xp2  = c3_x * f_s17(i_coef.p2);
        c5_xxp3 = $signed(f_pp_sum(r4_l3, r4_h3));
        c6_pn   = 21'd1048576 - {1'b0, r5_adcp};
        c7_den  = $signed(f_pp_sum(r6_l1, r6_h1));
        s8_side = '{temp: r8_temp, fine: r8_fine, zero: (r8_den == '0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_pv      <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[7:1], o_q_pop};
            r_pv      <= {r_pv[2:1], dv_vld};
            r_out_vld <= r_pv[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_xt   <= c1_xt >>> 11;
            r1_dd   <= c1_dd >>> 12;
            r1_adcp <= i_q_data.adc_p;

            r2_fine <= c2_fine;
            r2_adcp <= r1_adcp;

            r3_temp <= c3_t32[23:0];
            r3_fine <= r2_fine;
            r3_xx   <= c3_xx[63:0];
            r3_xp5  <= {{14{c3_xp5[49]}}, c3_xp5} << 17;
            r3_xp2  <= {{14{c3_xp2[49]}}, c3_xp2} << 12;
            r3_adcp <= r2_adcp;

            r4_l6   <= f_pp_lo(r3_xx, f_s17(i_coef.p6));
            r4_h6   <= f_pp_hi(r3_xx, f_s17(i_coef.p6));
            r4_l3   <= f_pp_lo(r3_xx, f_s17(i_coef.p3));
            r4_h3   <= f_pp_hi(r3_xx, f_s17(i_coef.p3));
            r4_xp5  <= r3_xp5;
            r4_xp2  <= r3_xp2;
            r4_temp <= r3_temp;
            r4_fine <= r3_fine;
            r4_adcp <= r3_adcp;

            r5_y    <= f_pp_sum(r4_l6, r4_h6) + r4_xp5
                     + ({{48{i_coef.p4[15]}}, i_coef.p4} << 35);
            r5_xv   <= $signed(c5_xxp3 >>> 8) + r4_xp2;
            r5_temp <= r4_temp;
            r5_fine <= r4_fine;
            r5_adcp <= r4_adcp;

            r6_l1   <= f_pp_lo(64'h0000_8000_0000_0000 + r5_xv, $signed({1'b0, i_coef.p1}));
            r6_h1   <= f_pp_hi(64'h0000_8000_0000_0000 + r5_xv, $signed({1'b0, i_coef.p1}));
            r6_num0 <= ({43'b0, c6_pn} << 31) - r5_y;
            r6_temp <= r5_temp;
            r6_fine <= r5_fine;

            r7_den  <= c7_den >>> 33;
            r7_l    <= f_pp_lo(r6_num0, 17'sd3125);
            r7_h    <= f_pp_hi(r6_num0, 17'sd3125);
            r7_temp <= r6_temp;
            r7_fine <= r6_fine;

            r8_num  <= f_pp_sum(r7_l, r7_h);
            r8_den  <= r7_den;
            r8_temp <= r7_temp;
            r8_fine <= r7_fine;
        end
    end

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (r_vld[8]),
        .i_num   (r8_num),
        .i_den   (r8_den),
        .i_side  (s8_side),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    always_comb begin
        cp_s   = $signed(dv_quo) >>> 13;
        cp_p8  = $signed(f_pp_sum(r_p1_l8, r_p1_h8));
        cp_x9  = $signed(f_pp_sum(r_p3_l9, r_p3_h9)) >>> 25;
        cp_sum = $signed(r_p3_q + cp_x9 + r_p3_yv) >>> 8;
        cp_pr  = cp_sum + $signed({{48{i_coef.p7[15]}}, i_coef.p7} << 4);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_ll   <= cp_s[31:0] * cp_s[31:0];
            r_p1_hl   <= cp_s[63:32] * cp_s[31:0];
            r_p1_l8   <= f_pp_lo(dv_quo, f_s17(i_coef.p8));
            r_p1_h8   <= f_pp_hi(dv_quo, f_s17(i_coef.p8));
            r_p1_q    <= dv_quo;
            r_p1_side <= dv_side;

            r_p2_ss   <= r_p1_ll + {r_p1_hl[30:0], 33'b0};
            r_p2_yv   <= cp_p8 >>> 19;
            r_p2_q    <= r_p1_q;
            r_p2_side <= r_p1_side;

            r_p3_l9   <= f_pp_lo(r_p2_ss, f_s17(i_coef.p9));
            r_p3_h9   <= f_pp_hi(r_p2_ss, f_s17(i_coef.p9));
            r_p3_q    <= r_p2_q;
            r_p3_yv   <= r_p2_yv;
            r_p3_side <= r_p2_side;

            r_out_temp <= r_p3_side.temp;
            r_out_fine <= r_p3_side.fine;
            r_out_pres <= r_p3_side.zero ? 24'd0 : cp_pr[31:8];
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_temperature_centi = r_out_temp;
    assign o_pressure_pa       = r_out_pres;
    assign o_fine_temperature  = r_out_fine;

endmodule

// ===== hw/rtl/baro_temp_press_compensation.sv =====
// Top level of the barometric temperature and pressure compensation block.
// Holds the calibration registers; depends on btpc_pkg, btpc_front, btpc_fifo, btpc_back.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         i_in_valid / o_in_stall    i_raw_temperature, i_raw_pressure
//   output   out        o_out_valid / i_out_stall  o_temperature_centi, o_pressure_pa,
//                                                  o_fine_temperature
//   config   in         psel / penable / pready    paddr, pwrite, pwdata, prdata
//
// One transfer is accepted every cycle while the queue is not full.
// Most of the latency is the divider: a sign stage, 64 quotient-bit stages and a negation.
// A four-entry queue decouples input from the pipeline; input stalls only when it is full.
// An output stall while a result is held freezes the back-end pipeline. Reset clears
// control state and the calibration registers.
module baro_temp_press_compensation import btpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [23:0] o_temperature_centi,
    output logic [23:0] o_pressure_pa,
    output logic [31:0] o_fine_temperature,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_a;
    logic [63:0] r_press_b;
    logic [15:0] r_press_nine;
    t_reg_idx    reg_sel;
    t_coef       coef;
    logic        push, pop, q_stall, q_empty;
    t_fentry     f_entry, q_entry;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_a     <= '0;
            r_press_b     <= '0;
            r_press_nine  <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_TEMP:       r_temp_coeffs <= pwdata[47:0];
                REG_PRESS_A:    r_press_a     <= pwdata;
                REG_PRESS_B:    r_press_b     <= pwdata;
                REG_PRESS_NINE: r_press_nine  <= pwdata[15:0];
                default:        r_press_nine  <= r_press_nine;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TEMP:       prdata = {16'b0, r_temp_coeffs};
            REG_PRESS_A:    prdata = r_press_a;
            REG_PRESS_B:    prdata = r_press_b;
            REG_PRESS_NINE: prdata = {48'b0, r_press_nine};
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        coef.t1 = r_temp_coeffs[15:0];
        coef.t2 = r_temp_coeffs[31:16];
        coef.t3 = r_temp_coeffs[47:32];
        coef.p1 = r_press_a[15:0];
        coef.p2 = r_press_a[31:16];
        coef.p3 = r_press_a[47:32];
        coef.p4 = r_press_a[63:48];
        coef.p5 = r_press_b[15:0];
        coef.p6 = r_press_b[31:16];
        coef.p7 = r_press_b[47:32];
        coef.p8 = r_press_b[63:48];
        coef.p9 = r_press_nine;
    end

    assign o_in_stall = q_stall;

    btpc_front u_front (
        .i_in_valid        (i_in_valid),
        .i_q_stall         (q_stall),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_t1              (coef.t1),
        .o_push            (push),
        .o_entry           (f_entry)
    );

    btpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_entry),
        .i_pop   (pop),
        .o_stall (q_stall),
        .o_empty (q_empty),
        .o_data  (q_entry)
    );

    btpc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_coef              (coef),
        .i_q_empty           (q_empty),
        .i_q_data            (q_entry),
        .o_q_pop             (pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_pa       (o_pressure_pa),
        .o_fine_temperature  (o_fine_temperature)
    );

endmodule

// ===== tb/baro_temp_press_compensation_chk.sv =====
`timescale 1ns / 1ps
// Checker for the barometric compensation block: watches both channels and the register port.
// Predicts each result from the accepted readings and the calibration words; uses btpc_pkg.
module baro_temp_press_compensation_chk import btpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [23:0] i_temperature_centi,
    input  logic [23:0] i_pressure_pa,
    input  logic [31:0] i_fine_temperature,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [23:0] temp;
        logic [23:0] pres;
        logic [31:0] fine;
    } t_result;

    logic [47:0] temp_cal;
    logic [63:0] press_cal_a;
    logic [63:0] press_cal_b;
    logic [15:0] press_cal_nine;
    t_result     expected_q[$];

    function automatic logic signed [63:0] half_word(input logic [63:0] r, input int idx);
        return 64'(signed'(r[16*idx +: 16]));
    endfunction

    function automatic t_result compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
        logic signed [31:0] a32, d32, x32, y32, fine, temp;
        logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] x, y, p, na, nb, ma, mb, q;
        t_result r;
        t1 = {48'd0, temp_cal[15:0]};
        t2 = half_word({16'd0, temp_cal}, 1);
        t3 = half_word({16'd0, temp_cal}, 2);
        p1 = {48'd0, press_cal_a[15:0]};
        p2 = half_word(press_cal_a, 1);
        p3 = half_word(press_cal_a, 2);
        p4 = half_word(press_cal_a, 3);
        p5 = half_word(press_cal_b, 0);
        p6 = half_word(press_cal_b, 1);
        p7 = half_word(press_cal_b, 2);
        p8 = half_word(press_cal_b, 3);
        p9 = 64'(signed'(press_cal_nine));
        a32 = 32'(adc_t >> 3) - 32'(t1 << 1);
        x32 = (a32 * 32'(t2)) >>> 11;
        d32 = 32'(adc_t >> 4) - 32'(t1);
        y32 = (d32 * d32) >>> 12;
        y32 = (y32 * 32'(t3)) >>> 14;
        fine = x32 + y32;
        temp = (fine * 5 + 128) >>> 8;
        x = 64'(fine) - 64'sd128000;
        y = x * x * p6;
        y = y + ((x * p5) <<< 17);
        y = y + (p4 <<< 35);
        x = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
        x = (((64'sd1 <<< 47) + x) * p1) >>> 33;
        r.temp = temp[23:0];
        r.fine = fine;
        if (x == 0) begin
            r.pres = '0;
        end else begin
            p = 64'sd1048576 - 64'(adc_p);
            na = ((p <<< 31) - y) * 64'sd3125;
            nb = x;
            ma = na[63] ? -na : na;
            mb = nb[63] ? -nb : nb;
            q = $signed($unsigned(ma) / $unsigned(mb));
            p = (na[63] ^ nb[63]) ? -q : q;
            x = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            y = (p8 * p) >>> 19;
            p = ((p + x + y) >>> 8) + (p7 <<< 4);
            r.pres = 24'(p[31:0] / 32'd256);
        end
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            temp_cal <= '0;
            press_cal_a <= '0;
            press_cal_b <= '0;
            press_cal_nine <= '0;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:3]))
                    REG_TEMP:       temp_cal <= pwdata[47:0];
                    REG_PRESS_A:    press_cal_a <= pwdata;
                    REG_PRESS_B:    press_cal_b <= pwdata;
                    REG_PRESS_NINE: press_cal_nine <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_q.push_back(compensate(i_raw_temperature, i_raw_pressure));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_temperature_centi, i_pressure_pa, i_fine_temperature};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected temp %h pres %h fine %h, got %h %h %h",
                                 $time, want.temp, want.pres, want.fine,
                                 got.temp, got.pres, got.fine);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/baro_temp_press_compensation_tb.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the barometric compensation block: clock, reset, stimulus, verdict.
// Depends on btpc_pkg, the block and baro_temp_press_compensation_chk.
module baro_temp_press_compensation_tb;
    import btpc_pkg::*;

    localparam int SILENCE_LIMIT = 20000;
    localparam int NUM_RANDOM    = 900;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic        out_valid;
    logic        out_stall;
    logic [23:0] temperature_centi;
    logic [23:0] pressure_pa;
    logic [31:0] fine_temperature;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          idle_pct;
    bit          hold_off;
    bit          hold_req;
    int          silent_cycles;

    baro_temp_press_compensation u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_raw_temperature(raw_temperature), .i_raw_pressure(raw_pressure),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_temperature_centi(temperature_centi), .o_pressure_pa(pressure_pa),
        .o_fine_temperature(fine_temperature),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    baro_temp_press_compensation_chk u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_raw_temperature(raw_temperature), .i_raw_pressure(raw_pressure),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_temperature_centi(temperature_centi), .i_pressure_pa(pressure_pa),
        .i_fine_temperature(fine_temperature),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 3;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_calibration(input logic [63:0] ct, input logic [63:0] ca,
                                     input logic [63:0] cb, input logic [15:0] c9);
        write_reg(REG_TEMP, ct);
        write_reg(REG_PRESS_A, ca);
        write_reg(REG_PRESS_B, cb);
        write_reg(REG_PRESS_NINE, {48'd0, c9});
    endtask

    // Typical calibration words with a random spread so the pressure path yields real values.
    task automatic load_typical();
        logic [15:0] h[12];
        h[0] = 16'd27504 + 16'($urandom_range(0, 2000));
        h[1] = 16'd26435 - 16'($urandom_range(0, 2000));
        h[2] = 16'($signed(-16'sd1000) + $signed(16'($urandom_range(0, 2000))));
        h[3] = 16'd36477 + 16'($urandom_range(0, 2000));
        h[4] = 16'(-16'sd10685 + $signed(16'($urandom_range(0, 2000))));
        h[5] = 16'd3024 + 16'($urandom_range(0, 500));
        h[6] = 16'd2855 + 16'($urandom_range(0, 500));
        h[7] = 16'd140 + 16'($urandom_range(0, 50));
        h[8] = 16'(-16'sd7) + 16'($urandom_range(0, 14));
        h[9] = 16'd15500;
        h[10] = 16'(-16'sd14600);
        h[11] = 16'd6000 + 16'($urandom_range(0, 1000));
        write_calibration({16'd0, h[2], h[1], h[0]}, {h[6], h[5], h[4], h[3]},
                          {h[10], h[9], h[8], h[7]}, h[11]);
    endtask

    task automatic send_item(input logic [19:0] t, input logic [19:0] p);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_temperature <= t;
        raw_pressure <= p;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_off) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            silent_cycles <= 0;
        end else begin
            silent_cycles <= silent_cycles + 1;
            if (silent_cycles >= SILENCE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [19:0] t;
        logic [19:0] p;
        int          mode;
        rst_n = 1'b0;
        in_valid = 1'b0;
        raw_temperature = '0;
        raw_pressure = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 14;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: the denominator is zero.
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        drain();
        load_typical();
        send_item(20'd519888, 20'd415148);
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'hFFFFF, 20'd0);
        send_item(20'd0, 20'hFFFFF);
        send_item(20'h55555, 20'hAAAAA);
        send_item(20'hAAAAA, 20'h55555);
        drain();
        write_calibration(64'hFFFF_FFFF_FFFF, '1, '1, 16'hFFFF);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'd0, 20'd0);
        send_item(20'h80000, 20'h80000);
        drain();
        write_calibration(64'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
                          64'h8000_8000_8000_8000, 16'h8000);
        send_item(20'hFFFFF, 20'd1);
        send_item(20'd0, 20'hFFFFF);
        send_item(20'd12345, 20'd54321);
        drain();
        write_calibration(64'h7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_0001,
                          64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'd0, 20'd0);
        drain();

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 150 == 0) begin
                drain();
                mode = i / 150;
                if (mode == 2) begin
                    write_calibration(rand64(), rand64(), rand64(), 16'($urandom()));
                end else begin
                    load_typical();
                end
                idle_pct = (mode == 3) ? 0 : 14;
            end
            if (i == 30) begin
                hold_req = 1'b1;
            end
            if ($urandom_range(0, 9) < 8) begin
                t = 20'd400000 + 20'($urandom_range(0, 250000));
                p = 20'd250000 + 20'($urandom_range(0, 250000));
            end else begin
                t = 20'($urandom());
                p = 20'($urandom());
            end
            send_item(t, p);
        end
        drain();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
